// ----- sv/assert_macros.svh -----
// assertion macros shared by the sorted list rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked on every clock edge outside reset
`define SLFR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent, outside reset
`define SLFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/slfr_pkg.sv -----
// types and constants of the sorted list block
package slfr_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned IdxW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned PosW  = 5;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_FIND   = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [PosW-1:0] position;
    logic [PosW-1:0] entry_count;
  } out_t;

  // per-transfer control broadcast to every cell
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctrl_t;

endpackage

// ----- sv/slfr_cell.sv -----
// one slot of the sorted list: holds a key, compares it, shifts with its neighbors
module slfr_cell
  import slfr_pkg::*;
(
  input  logic               clk_i,
  input  cell_ctrl_t         ctrl_i,
  input  logic signed [31:0] value_i,
  input  logic               occ_i,
  input  logic               left_lt_i,
  input  logic signed [31:0] left_entry_i,
  input  logic signed [31:0] right_entry_i,
  output logic signed [31:0] entry_o,
  output logic               lt_o,
  output logic               eq_o
);

  logic signed [31:0] entry_q, entry_d;

  assign lt_o    = occ_i && (entry_q < value_i);
  assign eq_o    = occ_i && (entry_q == value_i);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins && !lt_o) begin
      // first slot not below the key takes it, later ones move up
      entry_d = left_lt_i ? value_i : left_entry_i;
    end else if (ctrl_i.rem && !lt_o) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// ----- sv/sorted_list_insert_find_remove.sv -----
// top level of the sorted list: a row of slot cells, count and output register
// Keeps up to DEPTH signed keys in ascending order and handles one opcode per
// transfer: insert in front of the first key not below it, find the first equal
// key, or remove it and close the gap. One item is accepted every cycle unless a
// held result stalls it; its result lands in the output register on the accepting
// edge and is shown the next cycle, while the next item may already be taken.
// The cycle is set by the signed compare in every cell against the broadcast key
// and the encode of the one-hot boundary into a position. Slots are meaningful
// only below the count, so reset clears only count and valid, with no clearing pass.
module sorted_list_insert_find_remove
  import slfr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

`include "assert_macros.svh"

  localparam logic [PosW-1:0] PosNone = PosW'(DEPTH);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q;
  out_t            out_q, out_d;

  logic               in_fire;
  logic               full;
  logic               found;
  logic               ins_ok;
  logic               ins_full;
  cell_ctrl_t         ctrl;
  logic [IdxW-1:0]    pos_idx;
  logic [DEPTH-1:0]   lt, eq, bnd;
  logic signed [31:0] entry [DEPTH];

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign full        = (count_q == CntFull);
  assign ins_ok      = in_fire && (in_data_i.opcode == OP_INSERT) && !full;
  assign ins_full    = in_fire && (in_data_i.opcode == OP_INSERT) && full;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic               left_lt;
      logic signed [31:0] left_entry, right_entry;

      if (gi == 0) begin : g_first
        assign left_lt    = 1'b1;
        assign left_entry = in_data_i.value;
      end else begin : g_mid
        assign left_lt    = lt[gi-1];
        assign left_entry = entry[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign right_entry = entry[gi];
      end else begin : g_inner
        assign right_entry = entry[gi+1];
      end

      // one-hot mark of the first slot that is not below the key
      assign bnd[gi] = !lt[gi] && left_lt;

      slfr_cell u_cell (
        .clk_i        (clk_i),
        .ctrl_i       (ctrl),
        .value_i      (in_data_i.value),
        .occ_i        (CntW'(gi) < count_q),
        .left_lt_i    (left_lt),
        .left_entry_i (left_entry),
        .right_entry_i(right_entry),
        .entry_o      (entry[gi]),
        .lt_o         (lt[gi]),
        .eq_o         (eq[gi])
      );
    end
  endgenerate

  always_comb begin
    pos_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      pos_idx = pos_idx | (bnd[i] ? IdxW'(i) : '0);
    end
  end

  assign found = |(bnd & eq);

  always_comb begin
    ctrl    = '0;
    count_d = count_q;
    out_d   = out_q;
    if (in_fire) begin
      out_d.status   = ST_NOT_FOUND;
      out_d.position = PosNone;
      unique case (in_data_i.opcode)
        OP_INSERT: begin
          if (full) begin
            out_d.status = ST_FULL;
          end else begin
            ctrl.ins       = 1'b1;
            count_d        = count_q + 1'b1;
            out_d.status   = ST_OK;
            out_d.position = PosW'(pos_idx);
          end
        end
        OP_FIND: begin
          if (found) begin
            out_d.status   = ST_OK;
            out_d.position = PosW'(pos_idx);
          end
        end
        OP_REMOVE: begin
          if (found) begin
            ctrl.rem       = 1'b1;
            count_d        = count_q - 1'b1;
            out_d.status   = ST_OK;
            out_d.position = PosW'(pos_idx);
          end
        end
        default: begin
          out_d.status = ST_NOT_FOUND;
        end
      endcase
      out_d.entry_count = PosW'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  `SLFR_ASSERT(a_count_range, count_q <= CntFull, "entry count above depth")
  `SLFR_ASSERT(a_bnd_onehot, $onehot0(bnd), "more than one insert boundary")
  `SLFR_ASSERT_NEXT(a_idle_count, !in_fire, $stable(count_q), "count moved without transfer")
  `SLFR_ASSERT_NEXT(a_ins_count, ins_ok, count_q == $past(count_q) + 1'b1, "insert kept count")
  `SLFR_ASSERT_NEXT(a_full_flag, ins_full, out_q.status == ST_FULL, "full insert not flagged")
  `SLFR_ASSERT_NEXT(a_full_hold, ins_full, count_q == CntFull, "full insert moved count")

endmodule
